@@ hw/rtl/buddy_page_allocator_defines.svh @@
// ---------------------------------------------------------------------------
// buddy page allocator assertion macros
// shared assertion helpers for the allocator modules, empty when SYNTH is set
// ---------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
// property that must hold at every edge outside reset
`define BPA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition in one cycle implies a result in the next
`define BPA_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define BPA_ASSERT(lbl, clk, rst, prop, msg)
`define BPA_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif

`endif

@@ hw/rtl/bpa_pkg.sv @@
// ---------------------------------------------------------------------------
// buddy page allocator package
// sizes, codes and controller/datapath interface types
// ---------------------------------------------------------------------------
package bpa_pkg;

   // tree sizing
   localparam int MAX_PAGES  = 1024;
   localparam int MAX_ORDER  = $clog2(MAX_PAGES + 1) - 1;
   localparam int NODE_COUNT = (2 << MAX_ORDER) - 1;
   localparam int NODE_W     = MAX_ORDER + 1;
   localparam int VAL_W      = MAX_ORDER + 1;
   localparam int OFF_W      = MAX_ORDER;

   // field widths
   localparam int PAGES_W    = 11;
   localparam int OFFSET_W   = 10;
   localparam int STATUS_W   = 3;
   localparam int ORDER_W    = 4;
   localparam int AVAIL_W    = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int LVL_W      = $clog2(((MAX_ORDER > PAGES_W) ? MAX_ORDER : PAGES_W) + 2);

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_TREE_ORDER = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_AVAIL      = CSR_IDX_W'(1);

   localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(10);
   localparam logic [AVAIL_W-1:0] AVAIL_RESET = AVAIL_W'(1024);

   // request operation
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_NO_FIT    = 3'd1,
      ST_BEYOND    = 3'd2,
      ST_NOT_ALLOC = 3'd3,
      ST_RANGE     = 3'd4
   } status_type;

   // datapath commands
   typedef enum logic [3:0] {
      DP_IDLE       = 4'd0,
      DP_LOAD       = 4'd1,
      DP_BUILD_INIT = 4'd2,
      DP_BUILD      = 4'd3,
      DP_START      = 4'd4,
      DP_ROOT       = 4'd5,
      DP_DOWN       = 4'd6,
      DP_CHECK      = 4'd7,
      DP_FIND       = 4'd8,
      DP_UP         = 4'd9,
      DP_RESULT     = 4'd10
   } dp_cmd_type;

   // datapath status flags
   typedef struct packed {
      logic cfg_wr;
      logic build_last;
      logic func_free;
      logic range_fail;
      logic root_fail;
      logic lvl_at_need;
      logic lvl_next_need;
      logic beyond;
      logic idx_root;
      logic parent_root;
      logic node_used;
   } dp_status_type;

endpackage

@@ hw/rtl/buddy_page_allocator.sv @@
// ---------------------------------------------------------------------------
// buddy page allocator
// binary tree page allocator with allocate and free requests
// ---------------------------------------------------------------------------
// usage
// - req channel carries func (allocate or free), pages and offset; one
//   transfer per request, one rsp transfer with status and block_offset back
// - csr channel writes tree_order (index 0) or available_pages (index 1);
//   csr_ready is always high and a write to either rebuilds the tree, all pages free
// - one request at a time: req_stall stays high from a transfer until the
//   result has been loaded into the output register, so the next transfer
//   comes at the earliest in the cycle after that load
// - allocate walks the tree down from the root and then back up, free walks
//   up from the leaf of its offset; both read the node memory once per tree
//   level, and a refused allocate or an out of range free cuts the walk short
// - after reset and after every register write a setup step and a clearing
//   pass over all 2^(order+1)-1 nodes, one per cycle, keep req_stall high
// - while rsp_stall holds the result, the next request can be taken and
//   worked; it waits in the last step until the output register is free
// ---------------------------------------------------------------------------
module buddy_page_allocator (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_func,
   input  logic [bpa_pkg::PAGES_W-1:0]    req_pages,
   input  logic [bpa_pkg::OFFSET_W-1:0]   req_offset,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bpa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [bpa_pkg::OFFSET_W-1:0]   rsp_block_offset,
   // register write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bpa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bpa_pkg::CSR_DATA_W-1:0] csr_data
);
   import bpa_pkg::*;

   // controller to datapath commands and flags back
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // sequencing and handshakes
   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (dp_cmd),
      .status    (dp_status)
   );

   // node memory, walk state, registers and result payload
   bpa_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (dp_cmd),
      .status           (dp_status),
      .req_func         (req_func),
      .req_pages        (req_pages),
      .req_offset       (req_offset),
      .rsp_status       (rsp_status),
      .rsp_block_offset (rsp_block_offset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

endmodule

@@ hw/rtl/bpa_ram.sv @@
// ---------------------------------------------------------------------------
// generic ram
// one write port, one read port with registered read data
// ---------------------------------------------------------------------------
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/bpa_ctrl.sv @@
// ---------------------------------------------------------------------------
// buddy page allocator controller
// sequences tree build, descent and ascent, and owns the handshakes
// ---------------------------------------------------------------------------
`include "buddy_page_allocator_defines.svh"

module bpa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bpa_pkg::dp_cmd_type    cmd,
   input  bpa_pkg::dp_status_type status
);
   import bpa_pkg::*;

   typedef enum logic [9:0] {
      S_INIT   = 10'b0000000001,
      S_BUILD  = 10'b0000000010,
      S_IDLE   = 10'b0000000100,
      S_START  = 10'b0000001000,
      S_ROOT   = 10'b0000010000,
      S_DOWN   = 10'b0000100000,
      S_CHECK  = 10'b0001000000,
      S_FIND   = 10'b0010000000,
      S_UP     = 10'b0100000000,
      S_RESULT = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = DP_IDLE;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_INIT: begin
            cmd      = DP_BUILD_INIT;
            state_in = S_BUILD;
         end
         S_BUILD: begin
            cmd = DP_BUILD;
            if (status.build_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd      = DP_LOAD;
               state_in = S_START;
            end
         end
         S_START: begin
            cmd = DP_START;
            if (status.func_free) begin
               state_in = status.range_fail ? S_RESULT : S_FIND;
            end else begin
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            cmd = DP_ROOT;
            if (status.root_fail) state_in = S_RESULT;
            else if (status.lvl_at_need) state_in = S_CHECK;
            else state_in = S_DOWN;
         end
         S_DOWN: begin
            cmd = DP_DOWN;
            if (status.lvl_next_need) state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd = DP_CHECK;
            if (status.beyond || status.idx_root) state_in = S_RESULT;
            else state_in = S_UP;
         end
         S_FIND: begin
            cmd = DP_FIND;
            if (status.idx_root) state_in = S_RESULT;
            else if (status.node_used) state_in = S_UP;
         end
         S_UP: begin
            cmd = DP_UP;
            if (status.parent_root) state_in = S_RESULT;
         end
         S_RESULT: begin
            if (out_free) begin
               cmd          = DP_RESULT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
      // a write to either register rebuilds the tree
      if (status.cfg_wr) state_in = S_INIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `BPA_ASSERT(a_rsp_from_result, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_RESULT), "result raised outside result state")

endmodule

@@ hw/rtl/bpa_dp.sv @@
// ---------------------------------------------------------------------------
// buddy page allocator datapath
// node memory, walk registers, configuration and result registers
// ---------------------------------------------------------------------------
`include "buddy_page_allocator_defines.svh"

module bpa_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  bpa_pkg::dp_cmd_type               cmd,
   output bpa_pkg::dp_status_type            status,
   input  logic                              req_func,
   input  logic [bpa_pkg::PAGES_W-1:0]       req_pages,
   input  logic [bpa_pkg::OFFSET_W-1:0]      req_offset,
   output logic [bpa_pkg::STATUS_W-1:0]      rsp_status,
   output logic [bpa_pkg::OFFSET_W-1:0]      rsp_block_offset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bpa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bpa_pkg::CSR_DATA_W-1:0]    csr_data
);
   import bpa_pkg::*;

   // log2 of the page count rounded up to a power of two, zero counts as one
   function automatic logic [LVL_W-1:0] pages_log2(input logic [PAGES_W-1:0] p);
      logic [PAGES_W-1:0] pm1;
      logic [LVL_W-1:0]   r;
      pm1 = (p == '0) ? '0 : p - PAGES_W'(1);
      r   = '0;
      for (int i = 0; i < PAGES_W; i++) begin
         if (pm1[i]) r = LVL_W'(i + 1);
      end
      return r;
   endfunction

   logic [ORDER_W-1:0]  order_ff;
   logic [AVAIL_W-1:0]  avail_ff;
   logic                func_ff, func_in;
   logic [LVL_W-1:0]    need_lvl_ff, need_lvl_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [NODE_W-1:0]   idx_ff, idx_in;
   logic [LVL_W-1:0]    lvl_ff, lvl_in;
   logic [OFF_W-1:0]    off_ff, off_in;
   logic [VAL_W-1:0]    cur_ff, cur_in;
   status_type          res_ff, res_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [OFFSET_W-1:0] rsp_off_ff, rsp_off_in;

   logic                csr_fire;
   logic [LVL_W-1:0]    ord;
   logic [VAL_W-1:0]    total;
   logic [VAL_W-1:0]    need;
   logic [NODE_W-1:0]   left, child, child_left, parent, sib, parent_sib, leaf, build_end;
   logic                go_right;
   logic [LVL_W-1:0]    lvl_up;
   logic [VAL_W-1:0]    up_size, leaf_size, mx, up_val, build_val;
   logic [VAL_W:0]      sum;
   logic                build_first;

   logic                ram_wr_en, ram_rd_en;
   logic [NODE_W-1:0]   ram_wr_addr, ram_rd_addr;
   logic [VAL_W-1:0]    ram_wr_data, ram_rd_data;

   bpa_ram #(
      .WIDTH (VAL_W),
      .DEPTH (NODE_COUNT)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // configuration
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_RESET;
         avail_ff <= AVAIL_RESET;
      end else if (csr_fire) begin
         if (csr_index == CSR_TREE_ORDER) order_ff <= csr_data[ORDER_W-1:0];
         if (csr_index == CSR_AVAIL) avail_ff <= csr_data[AVAIL_W-1:0];
      end
   end

   // large orders clamp to the memory size
   assign ord   = (LVL_W'(order_ff) > LVL_W'(MAX_ORDER)) ? LVL_W'(MAX_ORDER)
                                                          : LVL_W'(order_ff);
   assign total = VAL_W'(1) << ord;
   assign need  = VAL_W'(1) << need_lvl_ff;

   // tree addressing
   assign left       = {idx_ff[NODE_W-2:0], 1'b0} + NODE_W'(1);
   assign go_right   = (ram_rd_data < need);
   assign child      = go_right ? left + NODE_W'(1) : left;
   assign child_left = {child[NODE_W-2:0], 1'b0} + NODE_W'(1);
   assign parent     = (idx_ff - NODE_W'(1)) >> 1;
   assign sib        = idx_ff[0] ? idx_ff + NODE_W'(1) : idx_ff - NODE_W'(1);
   assign parent_sib = parent[0] ? parent + NODE_W'(1) : parent - NODE_W'(1);
   assign leaf       = NODE_W'(offset_ff) + NODE_W'(total) - NODE_W'(1);
   assign build_end  = NODE_W'({total, 1'b0} - (VAL_W + 1)'(2));

   // node values on the way up
   assign lvl_up    = lvl_ff + LVL_W'(1);
   assign up_size   = VAL_W'(1) << lvl_up;
   assign leaf_size = VAL_W'(1) << lvl_ff;
   assign sum       = {1'b0, cur_ff} + {1'b0, ram_rd_data};
   assign mx        = (cur_ff > ram_rd_data) ? cur_ff : ram_rd_data;
   // buddies merge back only on free
   assign up_val    = (func_ff == FUNC_FREE && sum == {1'b0, up_size}) ? up_size : mx;

   // first node of each level halves the size
   assign build_first = (((idx_ff + NODE_W'(1)) & idx_ff) == '0) && (idx_ff != '0);
   assign build_val   = build_first ? (cur_ff >> 1) : cur_ff;

   // status back to the controller
   assign status.cfg_wr        = csr_fire && (csr_index == CSR_TREE_ORDER ||
                                              csr_index == CSR_AVAIL);
   assign status.build_last    = (idx_ff == build_end);
   assign status.func_free     = (func_ff == FUNC_FREE);
   assign status.range_fail    = ({{VAL_W{1'b0}}, offset_ff} >= {{OFFSET_W{1'b0}}, total});
   assign status.root_fail     = (need_lvl_ff > ord) || (ram_rd_data < need);
   assign status.lvl_at_need   = (lvl_ff == need_lvl_ff);
   assign status.lvl_next_need = ((lvl_ff - LVL_W'(1)) == need_lvl_ff);
   assign status.beyond        = ({{AVAIL_W{1'b0}}, off_ff} > {{OFF_W{1'b0}}, avail_ff});
   assign status.idx_root      = (idx_ff == '0);
   assign status.parent_root   = (parent == '0);
   assign status.node_used     = (ram_rd_data == '0);

   always_comb begin
      ram_wr_en     = 1'b0;
      ram_wr_addr   = idx_ff;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = idx_ff;
      func_in       = func_ff;
      need_lvl_in   = need_lvl_ff;
      offset_in     = offset_ff;
      idx_in        = idx_ff;
      lvl_in        = lvl_ff;
      off_in        = off_ff;
      cur_in        = cur_ff;
      res_in        = res_ff;
      rsp_status_in = rsp_status_ff;
      rsp_off_in    = rsp_off_ff;
      case (cmd)
         DP_LOAD: begin
            func_in     = req_func;
            need_lvl_in = pages_log2(req_pages);
            offset_in   = req_offset;
         end
         DP_BUILD_INIT: begin
            idx_in = '0;
            cur_in = total;
         end
         DP_BUILD: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff;
            ram_wr_data = build_val;
            cur_in      = build_val;
            idx_in      = idx_ff + NODE_W'(1);
         end
         DP_START: begin
            if (func_ff == FUNC_ALLOC) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = '0;
               idx_in      = '0;
               lvl_in      = ord;
               off_in      = '0;
            end else if (status.range_fail) begin
               res_in = ST_RANGE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = leaf;
               idx_in      = leaf;
               lvl_in      = '0;
            end
         end
         DP_ROOT: begin
            if (status.root_fail) begin
               res_in = ST_NO_FIT;
            end else if (!status.lvl_at_need) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = left;
            end
         end
         DP_DOWN: begin
            idx_in = child;
            lvl_in = lvl_ff - LVL_W'(1);
            if (go_right) off_in = off_ff | (OFF_W'(1) << (lvl_ff - LVL_W'(1)));
            if (!status.lvl_next_need) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = child_left;
            end
         end
         DP_CHECK: begin
            if (status.beyond) begin
               res_in = ST_BEYOND;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = idx_ff;
               ram_wr_data = '0;
               cur_in      = '0;
               res_in      = ST_OK;
               if (!status.idx_root) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = sib;
               end
            end
         end
         DP_FIND: begin
            if (!status.node_used) begin
               if (status.idx_root) begin
                  res_in = ST_NOT_ALLOC;
               end else begin
                  idx_in      = parent;
                  lvl_in      = lvl_up;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = parent;
               end
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = idx_ff;
               ram_wr_data = leaf_size;
               cur_in      = leaf_size;
               res_in      = ST_OK;
               if (!status.idx_root) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = sib;
               end
            end
         end
         DP_UP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = parent;
            ram_wr_data = up_val;
            cur_in      = up_val;
            idx_in      = parent;
            lvl_in      = lvl_up;
            if (!status.parent_root) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = parent_sib;
            end
         end
         DP_RESULT: begin
            rsp_status_in = res_ff;
            rsp_off_in    = (res_ff == ST_OK && func_ff == FUNC_ALLOC) ? OFFSET_W'(off_ff)
                                                                       : '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      need_lvl_ff   <= need_lvl_in;
      offset_ff     <= offset_in;
      idx_ff        <= idx_in;
      lvl_ff        <= lvl_in;
      off_ff        <= off_in;
      cur_ff        <= cur_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff    <= rsp_off_in;
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_block_offset = rsp_off_ff;

   `BPA_ASSERT(a_wr_in_tree, clock, reset, !ram_wr_en || (ram_wr_addr <= build_end), "node write outside the tree")
   `BPA_ASSERT(a_no_rw_same, clock, reset, !(ram_rd_en && ram_wr_en && (ram_rd_addr == ram_wr_addr)), "node read and write collide")
   `BPA_ASSERT(a_down_above_need, clock, reset, (cmd != DP_DOWN) || (lvl_ff > need_lvl_ff), "descent below request size")
   `BPA_ASSERT_NEXT(a_down_shrinks, clock, reset, (cmd == DP_DOWN), (lvl_ff < $past(lvl_ff)), "descent did not shrink block")

endmodule

@@ verif/tb_top.sv @@
// ---------------------------------------------------------------------------
// buddy page allocator testbench
// drives allocate and free requests and register writes into the allocator
// and checks every response against a behavioral copy of the page tree
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import bpa_pkg::*;

   localparam int WATCHDOG_LIMIT = 10000;
   localparam int DRAIN_CYCLES   = 64;
   localparam int PHASE_ITEMS    = 432;
   localparam int SEGMENTS       = 4;

   typedef struct {
      status_type             status;
      logic [OFFSET_W-1:0]    block_offset;
   } page_result_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #4ns clock = ~clock;

   // block inputs, all known from time zero
   logic                  req_valid  = 1'b0;
   logic                  req_func   = FUNC_ALLOC;
   logic [PAGES_W-1:0]    req_pages  = '0;
   logic [OFFSET_W-1:0]   req_offset = '0;
   logic                  rsp_stall  = 1'b0;
   logic                  csr_valid  = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = CSR_TREE_ORDER;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   // block outputs
   logic                  req_stall;
   logic                  rsp_valid;
   logic [STATUS_W-1:0]   rsp_status;
   logic [OFFSET_W-1:0]   rsp_block_offset;
   logic                  csr_ready;

   buddy_page_allocator u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_pages        (req_pages),
      .req_offset       (req_offset),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_block_offset (rsp_block_offset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // ------------------------------------------------------------------------
   // page tree copy: largest free run per node, root at 0, children 2k+1/2k+2
   // ------------------------------------------------------------------------
   logic [VAL_W-1:0]   free_run [NODE_COUNT];
   logic [ORDER_W-1:0] cfg_order;
   logic [AVAIL_W-1:0] cfg_avail;
   int                 tree_pages;

   // blocks the tree copy currently holds as allocated (first page and size)
   int unsigned held_base [$];
   int unsigned held_span [$];

   // responses still to come, oldest first
   page_result_type awaited_results [$];

   int  error_count   = 0;
   int  send_idle_pct = 22;
   int  rsp_stall_pct = 62;
   bit  req_held      = 1'b0;
   int  quiet_cycles  = 0;

   // every register write leaves all pages free
   function automatic void rebuild_tree();
      int ord;
      int span;
      ord = (int'(cfg_order) > MAX_ORDER) ? MAX_ORDER : int'(cfg_order);
      tree_pages = 1 << ord;
      span = tree_pages * 2;
      for (int i = 0; i < NODE_COUNT; i++)
         free_run[i] = '0;
      // first node of each level halves the run size
      for (int i = 0; i < 2 * tree_pages - 1; i++) begin
         if (((i + 1) & i) == 0)
            span = span / 2;
         free_run[i] = VAL_W'(span);
      end
      held_base.delete();
      held_span.delete();
   endfunction

   // applies one request to the tree copy and gives the expected response
   function automatic void buddy_predict(input logic func,
                                         input logic [PAGES_W-1:0] pages,
                                         input logic [OFFSET_W-1:0] offset,
                                         output status_type status,
                                         output logic [OFFSET_W-1:0] block_offset);
      int need;
      int idx;
      int span;
      int pos;
      int lsum;
      bit found;
      status       = ST_OK;
      block_offset = '0;
      if (func == FUNC_ALLOC) begin
         // zero pages round up to one like any other count
         need = 1;
         while (need < int'(pages))
            need = need * 2;
         if (int'(free_run[0]) < need) begin
            status = ST_NO_FIT;
         end else begin
            idx = 0;
            for (span = tree_pages; span != need; span = span / 2)
               idx = (int'(free_run[2*idx+1]) >= need) ? 2*idx + 1 : 2*idx + 2;
            pos = (idx + 1) * span - tree_pages;
            // offset equal to available_pages still passes
            if (pos > int'(cfg_avail)) begin
               status = ST_BEYOND;
            end else begin
               free_run[idx] = '0;
               while (idx != 0) begin
                  idx = (idx + 1) / 2 - 1;
                  free_run[idx] = (free_run[2*idx+1] > free_run[2*idx+2]) ?
                                  free_run[2*idx+1] : free_run[2*idx+2];
               end
               block_offset = OFFSET_W'(pos);
            end
         end
      end else if (int'(offset) >= tree_pages) begin
         status = ST_RANGE;
      end else begin
         // climb to the first used node, which is the enclosing block
         idx   = int'(offset) + tree_pages - 1;
         span  = 1;
         found = 1'b1;
         while (found && free_run[idx] != '0) begin
            span = span * 2;
            if (idx == 0)
               found = 1'b0;
            else
               idx = (idx + 1) / 2 - 1;
         end
         if (!found) begin
            status = ST_NOT_ALLOC;
         end else begin
            free_run[idx] = VAL_W'(span);
            // merge buddies that are both fully free
            while (idx != 0) begin
               idx  = (idx + 1) / 2 - 1;
               span = span * 2;
               lsum = int'(free_run[2*idx+1]) + int'(free_run[2*idx+2]);
               if (lsum == span)
                  free_run[idx] = VAL_W'(span);
               else
                  free_run[idx] = (free_run[2*idx+1] > free_run[2*idx+2]) ?
                                  free_run[2*idx+1] : free_run[2*idx+2];
            end
         end
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      error_count++;
   endtask

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   // one request transfer; the tree copy is updated at the accepting edge
   task automatic send_request(input logic func, input int unsigned pages,
                               input int unsigned offset);
      page_result_type result;
      status_type   status;
      logic [OFFSET_W-1:0] block_offset;
      int unsigned  blk;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_held   = 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_func   <= func;
      req_pages  <= PAGES_W'(pages);
      req_offset <= OFFSET_W'(offset);
      req_held    = 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      buddy_predict(func, PAGES_W'(pages), OFFSET_W'(offset), status, block_offset);
      result.status       = status;
      result.block_offset = block_offset;
      awaited_results.push_back(result);
      // keep the list of live blocks in step so frees can target them
      if (status == ST_OK && func == FUNC_ALLOC) begin
         blk = 1;
         while (blk < (pages & ((1 << PAGES_W) - 1)))
            blk = blk * 2;
         held_base.push_back(block_offset);
         held_span.push_back(blk);
      end else if (status == ST_OK) begin
         for (int k = 0; k < held_base.size(); k++)
            if ((offset & ((1 << OFFSET_W) - 1)) >= held_base[k] &&
                (offset & ((1 << OFFSET_W) - 1)) < held_base[k] + held_span[k]) begin
               held_base.delete(k);
               held_span.delete(k);
               break;
            end
      end
   endtask

   // drop valid and hold off until every response is back
   task automatic wait_for_results();
      if (req_held) begin
         req_valid <= 1'b0;
         req_held   = 1'b0;
      end
      while (awaited_results.size() != 0)
         @(posedge clock);
   endtask

   // register write while the block is idle, then wait out the clearing pass
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      wait_for_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_TREE_ORDER)
         cfg_order = ORDER_W'(value);
      else
         cfg_avail = AVAIL_W'(value);
      rebuild_tree();
      // clearing pass holds req_stall high until the tree is rebuilt
      repeat (2) @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // response side: random stall, compare each transfer with the oldest entry
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      page_result_type want;
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("response with none expected, status %0d offset %0d",
                                      rsp_status, rsp_block_offset));
         end else begin
            want = awaited_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d (%s)",
                                         rsp_status, want.status, want.status.name()));
            if (rsp_block_offset !== want.block_offset)
               report_mismatch($sformatf("block_offset %0d, expected %0d",
                                         rsp_block_offset, want.block_offset));
         end
      end
   end

   // watchdog: any stretch with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // default tree of 1024 pages: fits, misses, frees and merges
   task automatic test_alloc_free_basic();
      send_request(FUNC_ALLOC, 1, 0);
      send_request(FUNC_ALLOC, 0, 1023);      // zero pages behave as one
      send_request(FUNC_ALLOC, 2047, 0);      // larger than the whole tree
      send_request(FUNC_ALLOC, 1024, 0);      // root no longer holds 1024
      send_request(FUNC_FREE, 1024, 0);
      send_request(FUNC_FREE, 0, 0);          // nothing left there
      send_request(FUNC_FREE, 2047, 1);
      send_request(FUNC_ALLOC, 1024, 0);
      send_request(FUNC_FREE, 0, 1023);       // page inside the block frees it all
      send_request(FUNC_ALLOC, 512, 0);
      send_request(FUNC_ALLOC, 512, 0);
      send_request(FUNC_ALLOC, 1, 0);         // tree full
      send_request(FUNC_FREE, 0, 700);
   endtask

   // register extremes: single page tree, zero and odd availability,
   // order above the supported maximum
   task automatic test_config_extremes();
      write_csr(CSR_TREE_ORDER, 0);
      send_request(FUNC_ALLOC, 1, 0);
      send_request(FUNC_ALLOC, 1, 0);
      send_request(FUNC_FREE, 0, 1);          // beyond a one page tree
      send_request(FUNC_FREE, 0, 0);
      write_csr(CSR_AVAIL, 0);
      send_request(FUNC_ALLOC, 1, 0);         // offset 0 is not above 0
      write_csr(CSR_TREE_ORDER, 3);
      send_request(FUNC_ALLOC, 4, 0);
      send_request(FUNC_ALLOC, 1, 0);         // lands past available pages
      write_csr(CSR_AVAIL, 4);
      send_request(FUNC_ALLOC, 4, 0);
      send_request(FUNC_ALLOC, 4, 0);         // offset equal to available fits
      send_request(FUNC_FREE, 0, 1023);
      write_csr(CSR_TREE_ORDER, 15);          // clamps to the largest tree
      write_csr(CSR_AVAIL, 2047);
      send_request(FUNC_ALLOC, 1024, 0);
      send_request(FUNC_FREE, 0, 512);
      write_csr(CSR_AVAIL, 1);
      send_request(FUNC_ALLOC, 2, 0);
      send_request(FUNC_ALLOC, 2, 0);
   endtask

   // random traffic in segments, each on a fresh random configuration;
   // mostly allocs of fitting size and frees of live blocks, some noise
   task automatic run_random_phase(input int send_pct, input int recv_pct);
      int pick;
      int order;
      int k;
      send_idle_pct = send_pct;
      rsp_stall_pct = recv_pct;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         pick  = $urandom_range(0, 99);
         order = (pick < 60) ? $urandom_range(2, 6) :
                 (pick < 85) ? $urandom_range(7, 10) :
                 (pick < 95) ? $urandom_range(0, 1) : $urandom_range(11, 15);
         write_csr(CSR_TREE_ORDER, order);
         pick = $urandom_range(0, 99);
         write_csr(CSR_AVAIL, (pick < 60) ? tree_pages :
                              (pick < 90) ? $urandom_range(0, tree_pages) :
                                            $urandom_range(0, 2047));
         for (int n = 0; n < PHASE_ITEMS / SEGMENTS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
               send_request(1'($urandom_range(0, 1)), $urandom_range(0, 2047),
                            $urandom_range(0, 1023));
            end else if (pick < 55 && held_base.size() != 0) begin
               k = $urandom_range(0, held_base.size() - 1);
               send_request(FUNC_FREE, $urandom_range(0, 2047),
                            held_base[k] + $urandom_range(0, held_span[k] - 1));
            end else begin
               send_request(FUNC_ALLOC,
                            $urandom_range(1, 1 << $urandom_range(0, $clog2(tree_pages))),
                            $urandom_range(0, 1023));
            end
         end
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(22, 62);
      run_random_phase(62, 22);
      run_random_phase(0, 0);
   endtask

   initial begin
      cfg_order = ORDER_RESET;
      cfg_avail = AVAIL_RESET;
      rebuild_tree();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // clearing pass after reset
      repeat (2) @(posedge clock);
      while (req_stall)
         @(posedge clock);

      test_alloc_free_basic();
      test_config_extremes();
      test_random_traffic();

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
